@@ hdl/tlbfa_pkg.sv @@
// shared types and constants of the fully associative translation buffer
package tlbfa_pkg;

   // payload field widths seen at the ports
   localparam int PAGE_FIELD_W  = 8;
   localparam int FRAME_FIELD_W = 8;
   localparam int ACC_W         = 2;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_INVAL  = 2'd2,
      OP_FLUSH  = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type                opcode;
      logic [PAGE_FIELD_W-1:0]   page_number;
      logic [ACC_W-1:0]          access_bits;
      logic [FRAME_FIELD_W-1:0]  new_frame;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic [FRAME_FIELD_W-1:0]  frame_out;
      logic                      insert_dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } scan_state_type;

endpackage

@@ hdl/tlb_fully_associative.sv @@
// fully associative translation buffer, top level
//
// Request channel (req_valid/req_ready/req_data) takes one request at a time:
// lookup, insert, invalidate page or flush all. Every request gives exactly
// one response on the response channel (rsp_valid/rsp_ready/rsp_data).
// Entries sit in a single-port-read, single-port-write memory; a lookup,
// insert or invalidate walks the entries one per cycle in index order with
// one comparator, and stops at the first valid entry whose page matches.
// A flush clears all valid bits without a walk. A new request is taken in the
// cycle after the previous one has been handed to the response register.
// Valid bits are flip-flops and clear at reset; the entry memory has no reset
// and is only read through a valid entry.
// The response register holds its value while rsp_ready is low; the walker
// may accept and finish one more request, then waits until the register frees.
module tlb_fully_associative #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_BITS   = 8,
   parameter int FRAME_BITS  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tlbfa_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tlbfa_pkg::rsp_type rsp_data
);

   logic               done_valid;
   logic               done_ready;
   tlbfa_pkg::rsp_type done_data;
   logic               rsp_valid_ff, rsp_valid_in;
   tlbfa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   tlbfa_scan #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .PAGE_BITS   (PAGE_BITS),
      .FRAME_BITS  (FRAME_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_data  (done_data)
   );

   // response register
   always_comb begin
      done_ready   = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a finished request stays offered until the response register takes it
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      done_valid && !done_ready |=> done_valid)
      else $error("finished request lost before hand-off");

   // a hit and a dropped insert never come together
   a_hit_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.insert_dropped))
      else $error("response both hit and dropped");

   // no frame is returned without a hit
   a_frame_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.frame_out == '0)
      else $error("frame returned without hit");
`endif

endmodule

@@ hdl/tlbfa_entry_ram.sv @@
// entry memory: one write port, one registered read port
module tlbfa_entry_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int WIDTH  = 18
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hdl/tlbfa_scan.sv @@
// request sequencer: walks the entry memory, compares and updates entries
module tlbfa_scan #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_BITS   = 8,
   parameter int FRAME_BITS  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tlbfa_pkg::req_type req_data,
   output logic               done_valid,
   input  logic               done_ready,
   output tlbfa_pkg::rsp_type done_data
);

   // stored widths never exceed the port fields
   localparam int PW     = (PAGE_BITS < tlbfa_pkg::PAGE_FIELD_W) ?
                           PAGE_BITS : tlbfa_pkg::PAGE_FIELD_W;
   localparam int FW     = (FRAME_BITS < tlbfa_pkg::FRAME_FIELD_W) ?
                           FRAME_BITS : tlbfa_pkg::FRAME_FIELD_W;
   localparam int AW     = tlbfa_pkg::ACC_W;
   localparam int WIDTH  = PW + FW + AW;
   localparam int IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TLB_ENTRIES + 1);

   tlbfa_pkg::scan_state_type state_ff, state_in;
   tlbfa_pkg::req_type        req_ff, req_in;
   tlbfa_pkg::rsp_type        res_ff, res_in;
   logic [TLB_ENTRIES-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]          issue_ff, issue_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                      free_found_ff, free_found_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [WIDTH-1:0]  rd_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WIDTH-1:0]  wr_data;

   logic [PW-1:0]     ent_page;
   logic [FW-1:0]     ent_frame;
   logic [AW-1:0]     ent_perm;
   logic [PW-1:0]     req_page;
   logic              ent_valid;
   logic              match;
   logic              last;
   logic              resolve;
   logic              free_now;
   logic [IDX_W-1:0]  free_sel;

   tlbfa_entry_ram #(
      .DEPTH  (TLB_ENTRIES),
      .ADDR_W (IDX_W),
      .WIDTH  (WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // compare of the entry returned by the memory
   always_comb begin
      ent_page  = rd_data[WIDTH-1 -: PW];
      ent_frame = rd_data[AW +: FW];
      ent_perm  = rd_data[AW-1:0];
      req_page  = req_ff.page_number[PW-1:0];
      ent_valid = valid_ff[cmp_idx_ff];
      match     = cmp_vld_ff && ent_valid && (ent_page == req_page);
      last      = cmp_vld_ff && (cmp_idx_ff == IDX_W'(TLB_ENTRIES - 1));
      resolve   = match || last;
      free_now  = free_found_ff || !ent_valid;
      free_sel  = free_found_ff ? free_idx_ff : cmp_idx_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlbfa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.opcode == tlbfa_pkg::OP_FLUSH) ?
                          tlbfa_pkg::ST_DONE : tlbfa_pkg::ST_SCAN;
            end
         end
         tlbfa_pkg::ST_SCAN: begin
            if ((state_ff == tlbfa_pkg::ST_SCAN) && resolve) begin
               state_in = tlbfa_pkg::ST_DONE;
            end
         end
         tlbfa_pkg::ST_DONE: begin
            if (done_ready) begin
               state_in = tlbfa_pkg::ST_IDLE;
            end
         end
         default: state_in = tlbfa_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready     = (state_ff == tlbfa_pkg::ST_IDLE);
      done_valid    = (state_ff == tlbfa_pkg::ST_DONE);
      done_data     = res_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      valid_in      = valid_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rd_en         = 1'b0;
      rd_addr       = issue_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = cmp_idx_ff;
      wr_data       = {req_page, req_ff.new_frame[FW-1:0], req_ff.access_bits};
      case (state_ff)
         tlbfa_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               res_in        = '0;
               issue_in      = '0;
               free_found_in = 1'b0;
               if (req_data.opcode == tlbfa_pkg::OP_FLUSH) begin
                  valid_in = '0;
               end
            end
         end
         tlbfa_pkg::ST_SCAN: begin
            // issue the next memory read
            if (issue_ff < CNT_W'(TLB_ENTRIES)) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CNT_W'(1);
            end
            cmp_vld_in = rd_en;
            cmp_idx_in = rd_addr;
            // remember the lowest free slot
            if (cmp_vld_ff && !ent_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
            // act on the first match or at the end of the walk
            if (resolve) begin
               case (req_ff.opcode)
                  tlbfa_pkg::OP_LOOKUP: begin
                     if (match && ((ent_perm & req_ff.access_bits) == req_ff.access_bits))
                     begin
                        res_in.hit       = 1'b1;
                        res_in.frame_out = tlbfa_pkg::FRAME_FIELD_W'(ent_frame);
                     end
                  end
                  tlbfa_pkg::OP_INSERT: begin
                     if (match || free_now) begin
                        wr_en             = 1'b1;
                        wr_addr           = match ? cmp_idx_ff : free_sel;
                        valid_in[wr_addr] = 1'b1;
                     end else begin
                        res_in.insert_dropped = 1'b1;
                     end
                  end
                  tlbfa_pkg::OP_INVAL: begin
                     if (match) begin
                        valid_in[cmp_idx_ff] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tlbfa_pkg::ST_IDLE;
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      res_ff        <= res_in;
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
   end

endmodule

@@ test/tlb_checker.sv @@
// request/response checker for the fully associative translation buffer
`timescale 1ns / 100ps

module tlb_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  tlbfa_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  tlbfa_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 answers_pending
);

   localparam int TLB_DEPTH = 16;

   // shadow copy of the buffer contents
   logic                                ent_valid [TLB_DEPTH];
   logic [tlbfa_pkg::PAGE_FIELD_W-1:0]  ent_page  [TLB_DEPTH];
   logic [tlbfa_pkg::FRAME_FIELD_W-1:0] ent_frame [TLB_DEPTH];
   logic [tlbfa_pkg::ACC_W-1:0]         ent_perm  [TLB_DEPTH];

   // answers owed by the block, oldest first
   tlbfa_pkg::rsp_type tlb_answers [$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // applies one request to the shadow buffer and returns its answer
   function automatic tlbfa_pkg::rsp_type translate_request(input tlbfa_pkg::req_type r);
      tlbfa_pkg::rsp_type answer;
      int                 slot;
      answer = '0;
      slot   = -1;
      // lowest valid entry holding the page
      for (int i = 0; i < TLB_DEPTH; i++) begin
         if (slot < 0 && ent_valid[i] && ent_page[i] == r.page_number)
            slot = i;
      end
      case (r.opcode)
         tlbfa_pkg::OP_LOOKUP: begin
            if (slot >= 0 && (ent_perm[slot] & r.access_bits) == r.access_bits) begin
               answer.hit       = 1'b1;
               answer.frame_out = ent_frame[slot];
            end
         end
         tlbfa_pkg::OP_INSERT: begin
            // no match: take the lowest free entry
            if (slot < 0) begin
               for (int i = 0; i < TLB_DEPTH; i++) begin
                  if (slot < 0 && !ent_valid[i])
                     slot = i;
               end
            end
            if (slot < 0) begin
               answer.insert_dropped = 1'b1;
            end else begin
               ent_valid[slot] = 1'b1;
               ent_page[slot]  = r.page_number;
               ent_frame[slot] = r.new_frame;
               ent_perm[slot]  = r.access_bits;
            end
         end
         tlbfa_pkg::OP_INVAL: begin
            if (slot >= 0)
               ent_valid[slot] = 1'b0;
         end
         default: begin
            for (int i = 0; i < TLB_DEPTH; i++)
               ent_valid[i] = 1'b0;
         end
      endcase
      return answer;
   endfunction

   // watch both channels; responses first since one never answers a same-edge request
   always @(posedge clock) begin
      tlbfa_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < TLB_DEPTH; i++)
            ent_valid[i] = 1'b0;
         tlb_answers.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tlb_answers.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = tlb_answers.pop_front();
               if (rsp_data.hit !== want.hit)
                  report_mismatch($sformatf("hit got %b want %b",
                                            rsp_data.hit, want.hit));
               if (rsp_data.frame_out !== want.frame_out)
                  report_mismatch($sformatf("frame_out got %h want %h",
                                            rsp_data.frame_out, want.frame_out));
               if (rsp_data.insert_dropped !== want.insert_dropped)
                  report_mismatch($sformatf("insert_dropped got %b want %b",
                                            rsp_data.insert_dropped, want.insert_dropped));
            end
         end
         if (req_valid && req_ready)
            tlb_answers.push_back(translate_request(req_data));
      end
      answers_pending <= tlb_answers.size();
   end

endmodule

@@ test/testbench.sv @@
// stimulus and verdict for the fully associative translation buffer
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_ITEMS = 1025;
   localparam int POOL_SIZE    = 24;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   tlbfa_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   tlbfa_pkg::rsp_type rsp_data;
   logic               quiet_spell = 1'b0;
   int                 fail_count;
   int                 answers_pending;

   // small working set of pages so lookups and invalidates mostly find something
   logic [tlbfa_pkg::PAGE_FIELD_W-1:0] page_pool [POOL_SIZE];

   tlb_fully_associative u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tlb_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .answers_pending (answers_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side backpressure
   always @(posedge clock) begin
      rsp_ready <= quiet_spell || ($urandom_range(99) >= 17);
   end

   function automatic tlbfa_pkg::req_type make_req(
      input tlbfa_pkg::opcode_type                op,
      input logic [tlbfa_pkg::PAGE_FIELD_W-1:0]  page,
      input logic [tlbfa_pkg::ACC_W-1:0]         acc,
      input logic [tlbfa_pkg::FRAME_FIELD_W-1:0] frame);
      tlbfa_pkg::req_type r;
      r.opcode      = op;
      r.page_number = page;
      r.access_bits = acc;
      r.new_frame   = frame;
      return r;
   endfunction

   // lookups dominate, inserts keep the buffer near full, rare flushes
   function automatic tlbfa_pkg::req_type random_request();
      tlbfa_pkg::req_type r;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 50)
         r.opcode = tlbfa_pkg::OP_LOOKUP;
      else if (pick < 78)
         r.opcode = tlbfa_pkg::OP_INSERT;
      else if (pick < 97)
         r.opcode = tlbfa_pkg::OP_INVAL;
      else
         r.opcode = tlbfa_pkg::OP_FLUSH;
      if ($urandom_range(99) < 12)
         r.page_number = tlbfa_pkg::PAGE_FIELD_W'($urandom_range(255));
      else
         r.page_number = page_pool[$urandom_range(POOL_SIZE-1)];
      r.access_bits = tlbfa_pkg::ACC_W'($urandom_range(3));
      r.new_frame   = tlbfa_pkg::FRAME_FIELD_W'($urandom_range(255));
      return r;
   endfunction

   // present one request and hold it until taken
   task automatic send_request(input tlbfa_pkg::req_type r, input bit allow_gaps);
      while (allow_gaps && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   initial begin
      tlbfa_pkg::req_type directed [$];
      for (int i = 0; i < POOL_SIZE; i++)
         page_pool[i] = tlbfa_pkg::PAGE_FIELD_W'($urandom_range(255));
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: permissions, overwrite, invalidate, fill to full, flush
      directed.push_back(make_req(tlbfa_pkg::OP_LOOKUP, 8'hFF, 2'd0, 8'h00));
      directed.push_back(make_req(tlbfa_pkg::OP_INSERT, 8'hFF, 2'd3, 8'hFF));
      directed.push_back(make_req(tlbfa_pkg::OP_LOOKUP, 8'hFF, 2'd3, 8'h00));
      directed.push_back(make_req(tlbfa_pkg::OP_INSERT, 8'hFF, 2'd1, 8'h00));
      directed.push_back(make_req(tlbfa_pkg::OP_LOOKUP, 8'hFF, 2'd2, 8'hA5));
      directed.push_back(make_req(tlbfa_pkg::OP_LOOKUP, 8'hFF, 2'd0, 8'h5A));
      directed.push_back(make_req(tlbfa_pkg::OP_INVAL,  8'h42, 2'd3, 8'hFF));
      directed.push_back(make_req(tlbfa_pkg::OP_INVAL,  8'hFF, 2'd0, 8'h00));
      for (int i = 0; i < 16; i++)
         directed.push_back(make_req(tlbfa_pkg::OP_INSERT, 8'(i * 17), 2'(i),
                                     8'(255 - i * 16)));
      directed.push_back(make_req(tlbfa_pkg::OP_INSERT, 8'h80, 2'd3, 8'h3C));
      directed.push_back(make_req(tlbfa_pkg::OP_INSERT, 8'h00, 2'd2, 8'hC3));
      directed.push_back(make_req(tlbfa_pkg::OP_LOOKUP, 8'h00, 2'd2, 8'h00));
      directed.push_back(make_req(tlbfa_pkg::OP_FLUSH,  8'h00, 2'd0, 8'h00));
      directed.push_back(make_req(tlbfa_pkg::OP_LOOKUP, 8'hFF, 2'd0, 8'h00));
      foreach (directed[k])
         send_request(directed[k], 1'b1);

      // random traffic with one long stretch free of gaps and stalls
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_spell <= (n >= 400 && n < 600);
         send_request(random_request(), !(n >= 400 && n < 600));
      end
      req_valid   <= 1'b0;
      quiet_spell <= 1'b0;

      // drain, then allow for a full scan of trailing activity
      @(posedge clock);
      while (answers_pending != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
